>>> sv/fbc_pkg.sv
package fbc_pkg;

	localparam int NUM_PLANE_REGS = 6;
	localparam int REG_IDX_BITS = 3;
	localparam int PLANE_BITS = 64;
	localparam int NORM_BITS = 16;
	localparam int FRAC_BITS = 14;
	localparam int D_ALIGNED_BITS = NORM_BITS + FRAC_BITS;
	localparam int CNT_BITS = 16;
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = 2;

	typedef enum logic [1:0] {
		CLS_OUTSIDE   = 2'd0,
		CLS_INTERSECT = 2'd1,
		CLS_INSIDE    = 2'd2,
		CLS_INVALID   = 2'd3
	} class_t;

	typedef struct packed {
		logic   list_start;
		class_t class_code;
	} item_t;

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
		return (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

>>> sv/frustum_box_cull_with_stats.sv
// Frustum culling of axis-aligned boxes with running statistics.
// Input side is a queue write port: present a box with push; it is taken
// at a clock edge where push is high and full is low. Result side is a
// queue read port: while empty is low the oldest result sits on visible,
// class_code and the three counters; pop takes it.
// The user loads planes through wr_en/wr_index/wr_data only while no box
// is in flight; the block itself does not enforce this. Indexes past the
// plane list are ignored. Throughput is one box per cycle while full is
// low. A box passes one input register, one multiplier stage, one
// distance and classify stage, then the queue and the output register.
// When the receiver stalls, the output register holds and a 4-word queue
// keeps the classify pipe running; once it fills, full rises and the pipe
// holds.
// Reset clears all planes (every box but an all-zero one then classifies
// as inside), the counters and the queue.
module frustum_box_cull_with_stats #(
	parameter int COORD_BITS = 16,
	parameter int PLANE_COUNT = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [fbc_pkg::REG_IDX_BITS-1:0]      wr_index,
	input  logic [fbc_pkg::PLANE_BITS-1:0]        wr_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  list_start,
	input  logic signed [COORD_BITS-1:0]          box_min_x,
	input  logic signed [COORD_BITS-1:0]          box_min_y,
	input  logic signed [COORD_BITS-1:0]          box_min_z,
	input  logic signed [COORD_BITS-1:0]          box_max_x,
	input  logic signed [COORD_BITS-1:0]          box_max_y,
	input  logic signed [COORD_BITS-1:0]          box_max_z,
	output logic                                  empty,
	input  logic                                  pop,
	output logic                                  visible,
	output logic [1:0]                            class_code,
	output logic [fbc_pkg::CNT_BITS-1:0]          total_seen,
	output logic [fbc_pkg::CNT_BITS-1:0]          visible_seen,
	output logic [fbc_pkg::CNT_BITS-1:0]          culled_seen
);
	import fbc_pkg::*;

	logic [PLANE_BITS-1:0] planes_q [NUM_PLANE_REGS];
	logic signed [COORD_BITS-1:0] box_lo [3];
	logic signed [COORD_BITS-1:0] box_hi [3];
	logic front_valid, q_full, q_empty, back_take;
	item_t front_item, q_item;
	class_t cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANE_REGS; i++) begin
				planes_q[i] <= '0;
			end
		end else if (wr_en && (wr_index < REG_IDX_BITS'(NUM_PLANE_REGS))) begin
			planes_q[wr_index] <= wr_data;
		end
	end

	assign box_lo[0] = box_min_x;
	assign box_lo[1] = box_min_y;
	assign box_lo[2] = box_min_z;
	assign box_hi[0] = box_max_x;
	assign box_hi[1] = box_max_y;
	assign box_hi[2] = box_max_z;

	fbc_front #(
		.COORD_BITS (COORD_BITS),
		.PLANE_COUNT(PLANE_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.planes    (planes_q),
		.push      (push),
		.full      (full),
		.list_start(list_start),
		.box_lo    (box_lo),
		.box_hi    (box_hi),
		.out_valid (front_valid),
		.out_item  (front_item),
		.out_ready (!q_full)
	);

	fbc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (front_valid),
		.full  (q_full),
		.din   (front_item),
		.pop   (back_take),
		.empty (q_empty),
		.dout  (q_item)
	);

	fbc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (!q_empty),
		.in_item     (q_item),
		.in_take     (back_take),
		.empty       (empty),
		.pop         (pop),
		.visible     (visible),
		.class_code  (cls),
		.total_seen  (total_seen),
		.visible_seen(visible_seen),
		.culled_seen (culled_seen)
	);

	assign class_code = 2'(cls);

endmodule

>>> sv/fbc_front.sv
module fbc_front #(
	parameter int COORD_BITS = 16,
	parameter int PLANE_COUNT = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [fbc_pkg::PLANE_BITS-1:0]        planes [fbc_pkg::NUM_PLANE_REGS],
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  list_start,
	input  logic signed [COORD_BITS-1:0]          box_lo [3],
	input  logic signed [COORD_BITS-1:0]          box_hi [3],
	output logic                                  out_valid,
	output fbc_pkg::item_t                        out_item,
	input  logic                                  out_ready
);
	import fbc_pkg::*;

	// planes past the register file are not built; at most NUM_PLANE_REGS are used
	localparam int ACT = (PLANE_COUNT < NUM_PLANE_REGS) ? PLANE_COUNT : NUM_PLANE_REGS;
	localparam int PW = COORD_BITS + NORM_BITS;
	localparam int DW = ((PW > D_ALIGNED_BITS) ? PW : D_ALIGNED_BITS) + 2;

	logic en;
	logic valid_s1, valid_s2, valid_s3;
	logic ls_s1, ls_s2, ls_s3;
	logic zero_s1, zero_s2;
	logic signed [COORD_BITS-1:0] lo_s1 [3];
	logic signed [COORD_BITS-1:0] hi_s1 [3];
	logic [ACT-1:0] pneg, nneg;
	class_t cls_next, cls_s3;

	// whole pipe holds while the last stage waits on the queue
	assign en = !valid_s3 || out_ready;
	assign full = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= push;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1 <= box_lo;
			hi_s1 <= box_hi;
			ls_s1 <= list_start;
			zero_s1 <= (box_lo[0] == '0) && (box_lo[1] == '0) && (box_lo[2] == '0) &&
				(box_hi[0] == '0) && (box_hi[1] == '0) && (box_hi[2] == '0);
			ls_s2 <= ls_s1;
			zero_s2 <= zero_s1;
			ls_s3 <= ls_s2;
			cls_s3 <= cls_next;
		end
	end

	for (genvar i = 0; i < ACT; i++) begin : g_plane
		logic signed [NORM_BITS-1:0] nrm [3];
		logic signed [NORM_BITS-1:0] d;
		logic signed [COORD_BITS-1:0] pv [3];
		logic signed [COORD_BITS-1:0] nv [3];
		logic signed [PW-1:0] pp_s2 [3];
		logic signed [PW-1:0] np_s2 [3];
		logic signed [DW-1:0] dterm, pdist, ndist;

		always_comb begin
			for (int j = 0; j < 3; j++) begin
				nrm[j] = planes[i][NORM_BITS*j +: NORM_BITS];
				// positive vertex takes the max where the normal points up that axis
				pv[j] = (nrm[j] > 0) ? hi_s1[j] : lo_s1[j];
				nv[j] = (nrm[j] > 0) ? lo_s1[j] : hi_s1[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					pp_s2[j] <= nrm[j] * pv[j];
					np_s2[j] <= nrm[j] * nv[j];
				end
			end
		end

		assign d = planes[i][PLANE_BITS-1 -: NORM_BITS];
		assign dterm = {{(DW-D_ALIGNED_BITS){d[NORM_BITS-1]}}, d, {FRAC_BITS{1'b0}}};
		assign pdist = {{(DW-PW){pp_s2[0][PW-1]}}, pp_s2[0]}
			+ {{(DW-PW){pp_s2[1][PW-1]}}, pp_s2[1]}
			+ {{(DW-PW){pp_s2[2][PW-1]}}, pp_s2[2]} + dterm;
		assign ndist = {{(DW-PW){np_s2[0][PW-1]}}, np_s2[0]}
			+ {{(DW-PW){np_s2[1][PW-1]}}, np_s2[1]}
			+ {{(DW-PW){np_s2[2][PW-1]}}, np_s2[2]} + dterm;
		assign pneg[i] = pdist[DW-1];
		assign nneg[i] = ndist[DW-1];
	end

	always_comb begin
		if (zero_s2) begin
			cls_next = CLS_INVALID;
		end else if (|pneg) begin
			cls_next = CLS_OUTSIDE;
		end else if (|nneg) begin
			cls_next = CLS_INTERSECT;
		end else begin
			cls_next = CLS_INSIDE;
		end
	end

	assign out_valid = valid_s3;
	assign out_item = '{list_start: ls_s3, class_code: cls_s3};

endmodule

>>> sv/fbc_queue.sv
module fbc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  fbc_pkg::item_t din,
	input  logic           pop,
	output logic           empty,
	output fbc_pkg::item_t dout
);
	import fbc_pkg::*;

	item_t mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_PTR_BITS:0] count_q;
	logic do_push, do_pop;

	assign full = count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/fbc_back.sv
module fbc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  fbc_pkg::item_t                in_item,
	output logic                          in_take,
	output logic                          empty,
	input  logic                          pop,
	output logic                          visible,
	output fbc_pkg::class_t               class_code,
	output logic [fbc_pkg::CNT_BITS-1:0]  total_seen,
	output logic [fbc_pkg::CNT_BITS-1:0]  visible_seen,
	output logic [fbc_pkg::CNT_BITS-1:0]  culled_seen
);
	import fbc_pkg::*;

	logic out_valid_q;
	logic vis_q;
	class_t cls_q;
	logic [CNT_BITS-1:0] total_q, vis_cnt_q, cull_cnt_q;
	logic [CNT_BITS-1:0] total_base, vis_base, cull_base;
	logic is_vis;

	assign in_take = in_valid && (!out_valid_q || pop);
	assign is_vis = in_item.class_code != CLS_OUTSIDE;

	// list start drops the old counts before this word is counted
	assign total_base = in_item.list_start ? '0 : total_q;
	assign vis_base = in_item.list_start ? '0 : vis_cnt_q;
	assign cull_base = in_item.list_start ? '0 : cull_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q <= '0;
			vis_cnt_q <= '0;
			cull_cnt_q <= '0;
		end else begin
			if (in_take) begin
				out_valid_q <= 1'b1;
				total_q <= sat_inc(total_base);
				vis_cnt_q <= is_vis ? sat_inc(vis_base) : vis_base;
				cull_cnt_q <= is_vis ? cull_base : sat_inc(cull_base);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			vis_q <= is_vis;
			cls_q <= in_item.class_code;
		end
	end

	assign empty = !out_valid_q;
	assign visible = vis_q;
	assign class_code = cls_q;
	assign total_seen = total_q;
	assign visible_seen = vis_cnt_q;
	assign culled_seen = cull_cnt_q;

endmodule
